[rtl/core/lbl_pkg.sv]
package lbl_pkg;

    // Table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int FAIL_W   = 8;
    localparam int DELAY_W  = 17;
    localparam int BLOCK_W  = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DELAY_W-1:0] RETRY_MAX = {DELAY_W{1'b1}};

    // Commands
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FAILURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SUCCESS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION     = 2'd3;

    // Arithmetic unit operations
    localparam logic ALU_SUB = 1'b0;
    localparam logic ALU_ADD = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   user;
        logic [KEY_W-1:0]   addr;
        logic [FAIL_W-1:0]  failures;
        logic [BLOCK_W-1:0] block_end;
        logic [TIME_W-1:0]  last_fail;
    } t_entry;

    typedef struct packed {
        logic               op;
        logic [BLOCK_W-1:0] a;
        logic [BLOCK_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [BLOCK_W-1:0] res;
        logic               carry;
    } t_alu_rsp;

endpackage

[rtl/core/lbl_ifs.sv]
interface lbl_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [lbl_pkg::CMD_W-1:0]    cmd;
    logic [lbl_pkg::KEY_W-1:0]    user_id;
    logic [lbl_pkg::KEY_W-1:0]    remote_addr;
    logic [lbl_pkg::TIME_W-1:0]   now_seconds;

    modport source (output valid, cmd, user_id, remote_addr, now_seconds, input ready);
    modport sink   (input valid, cmd, user_id, remote_addr, now_seconds, output ready);
endinterface

interface lbl_res_if;
    logic                         valid;
    logic                         ready;
    logic                         access_allowed;
    logic [lbl_pkg::DELAY_W-1:0]  retry_after;
    logic                         table_full;

    modport source (output valid, access_allowed, retry_after, table_full, input ready);
    modport sink   (input valid, access_allowed, retry_after, table_full, output ready);
endinterface

interface lbl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lbl_pkg::CFG_IDX_W-1:0]   index;
    logic [lbl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/lbl_alu.sv]
module lbl_alu (
    input  lbl_pkg::t_alu_req i_req,
    output lbl_pkg::t_alu_rsp o_rsp
);

    logic [lbl_pkg::BLOCK_W:0] sum;

    // Add or subtract on 33 bits; top bit is carry or borrow
    always_comb begin
        if (i_req.op == lbl_pkg::ALU_ADD) begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    assign o_rsp.res   = sum[lbl_pkg::BLOCK_W-1:0];
    assign o_rsp.carry = sum[lbl_pkg::BLOCK_W];

endmodule

[rtl/core/login_backoff_lockout_table_unit.sv]
// Lockout table for login attempts, keyed by user id and remote address.
// Commands arrive on i_cmd_ch (check, failure, success, reset user); each
// command yields exactly one result on o_res_ch (access_allowed,
// retry_after, table_full). Registers are written on i_cfg_ch, which is
// always ready; write them only while no command is in flight.
// Each command scans all 64 entries through the entry memory (one write
// port, one registered read port), one entry per cycle; check and failure
// commands then finish with steps on one shared add/subtract unit. A
// recorded failure doubles its delay once per step, at most 17 times,
// before its entry is written. The sequencer returns to idle before the
// next transfer in.
// i_cmd_ch.ready is high only while the sequencer is idle, so one command
// is processed at a time. The result sits in an output register; the next
// command is accepted while it waits, and a finished result holds in the
// sequencer until the receiver takes the previous one.
// Reset clears all valid bits at once and loads the register defaults
// (failure limit 10, initial_delay 1, max_delay 300, retention 3600).
module login_backoff_lockout_table_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lbl_cmd_if.sink      i_cmd_ch,
    lbl_cfg_if.sink      i_cfg_ch,
    lbl_res_if.source    o_res_ch
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_DRAIN   = 4'd2;
    localparam logic [3:0] ST_DECIDE  = 4'd3;
    localparam logic [3:0] ST_CK_ELAP = 4'd4;
    localparam logic [3:0] ST_CK_RET  = 4'd5;
    localparam logic [3:0] ST_CK_BLK  = 4'd6;
    localparam logic [3:0] ST_FL_DLY  = 4'd7;
    localparam logic [3:0] ST_FL_ADD  = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    localparam int IW = lbl_pkg::IDX_W;

    // Configuration
    logic [lbl_pkg::FAIL_W-1:0]  r_max_fail;
    logic [lbl_pkg::DELAY_W-1:0] r_init_dly;
    logic [lbl_pkg::DELAY_W-1:0] r_max_dly;
    logic [lbl_pkg::TIME_W-1:0]  r_retention;

    // Command context
    logic [3:0]                  r_state;
    logic [lbl_pkg::CMD_W-1:0]   r_cmd;
    logic [lbl_pkg::KEY_W-1:0]   r_user;
    logic [lbl_pkg::KEY_W-1:0]   r_addr;
    logic [lbl_pkg::TIME_W-1:0]  r_now;

    // Scan
    logic [IW-1:0]               r_scan_idx;
    logic                        r_cmp_vld;
    logic [IW-1:0]               r_cmp_idx;
    logic [lbl_pkg::ENTRIES-1:0] r_valid;
    logic                        r_match;
    logic [IW-1:0]               r_slot;
    logic                        r_free_found;
    logic [IW-1:0]               r_free_idx;
    logic [lbl_pkg::FAIL_W-1:0]  r_e_fail;
    logic [lbl_pkg::BLOCK_W-1:0] r_e_blk;
    logic [lbl_pkg::TIME_W-1:0]  r_e_last;

    // Work registers
    logic [lbl_pkg::TIME_W-1:0]  r_elapsed;
    logic [lbl_pkg::FAIL_W-1:0]  r_n;
    logic [lbl_pkg::FAIL_W-1:0]  r_k;
    logic [lbl_pkg::DELAY_W-1:0] r_dly;
    logic                        r_res_allowed;
    logic [lbl_pkg::DELAY_W-1:0] r_res_retry;
    logic                        r_res_full;

    // Output register
    logic                        r_out_valid;
    logic                        r_out_allowed;
    logic [lbl_pkg::DELAY_W-1:0] r_out_retry;
    logic                        r_out_full;

    // Entry memory
    lbl_pkg::t_entry             r_mem [lbl_pkg::ENTRIES];
    lbl_pkg::t_entry             r_rd_data;

    lbl_pkg::t_alu_req           alu_req;
    lbl_pkg::t_alu_rsp           alu_rsp;
    logic                        cmp_hit;
    logic                        mem_we;
    logic [IW-1:0]               wr_idx;
    lbl_pkg::t_entry             wr_data;
    logic [lbl_pkg::FAIL_W-1:0]  base_fail;
    logic [lbl_pkg::FAIL_W:0]    inc_fail;
    logic [lbl_pkg::FAIL_W-1:0]  n_fail_cnt;
    logic [lbl_pkg::DELAY_W:0]   dly_dbl;
    logic [lbl_pkg::DELAY_W-1:0] n_dly;
    logic                        dly_go;

    assign i_cmd_ch.ready = (r_state == ST_IDLE);
    assign i_cfg_ch.ready = 1'b1;

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.access_allowed = r_out_allowed;
    assign o_res_ch.retry_after    = r_out_retry;
    assign o_res_ch.table_full     = r_out_full;

    // Shared arithmetic unit
    lbl_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Steer operands by sequencer step
    always_comb begin
        alu_req.op = lbl_pkg::ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (r_state)
            ST_CK_ELAP: begin
                alu_req.a = {1'b0, r_now};
                alu_req.b = {1'b0, r_e_last};
            end
            ST_CK_RET: begin
                alu_req.a = {1'b0, r_retention};
                alu_req.b = {1'b0, r_elapsed};
            end
            ST_CK_BLK: begin
                alu_req.a = r_e_blk;
                alu_req.b = {1'b0, r_now};
            end
            ST_FL_ADD: begin
                alu_req.op = lbl_pkg::ALU_ADD;
                alu_req.a  = {1'b0, r_now};
                alu_req.b  = {{(lbl_pkg::BLOCK_W-lbl_pkg::DELAY_W){1'b0}}, r_dly};
            end
            default: begin
                alu_req.op = lbl_pkg::ALU_SUB;
            end
        endcase
    end

    // Key compare on the entry read last cycle
    assign cmp_hit = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_data.user == r_user) &&
                     ((r_cmd == lbl_pkg::CMD_RESET) || (r_rd_data.addr == r_addr));

    // Saturating failure count
    assign base_fail  = r_match ? r_e_fail : '0;
    assign inc_fail   = {1'b0, base_fail} + {{lbl_pkg::FAIL_W{1'b0}}, 1'b1};
    assign n_fail_cnt = (inc_fail > {1'b0, r_max_fail}) ? r_max_fail
                                                        : inc_fail[lbl_pkg::FAIL_W-1:0];

    // One doubling step, clamped at max_delay
    assign dly_dbl = {r_dly, 1'b0};
    assign n_dly   = (dly_dbl > {1'b0, r_max_dly}) ? r_max_dly
                                                   : dly_dbl[lbl_pkg::DELAY_W-1:0];
    assign dly_go  = (r_k < r_n) && (r_dly < r_max_dly) && (r_dly != '0);

    // Entry write on failure
    assign mem_we  = (r_state == ST_FL_ADD);
    assign wr_idx  = r_match ? r_slot : r_free_idx;
    assign wr_data = '{user: r_user, addr: r_addr, failures: r_n,
                       block_end: alu_rsp.res, last_fail: r_now};

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (r_state == ST_SCAN) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    // Payload registers of the scan
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan_idx;
        if (cmp_hit && !r_match) begin
            r_slot   <= r_cmp_idx;
            r_e_fail <= r_rd_data.failures;
            r_e_blk  <= r_rd_data.block_end;
            r_e_last <= r_rd_data.last_fail;
        end
        if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_cmp_vld    <= 1'b0;
            r_match      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_fail   <= 8'd10;
            r_init_dly   <= 17'd1;
            r_max_dly    <= 17'd300;
            r_retention  <= 32'd3600;
        end else begin
            // Register writes
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.index)
                    lbl_pkg::CFG_FAIL_LIMIT:    r_max_fail  <= i_cfg_ch.data[lbl_pkg::FAIL_W-1:0];
                    lbl_pkg::CFG_INITIAL_DELAY: r_init_dly  <= i_cfg_ch.data[lbl_pkg::DELAY_W-1:0];
                    lbl_pkg::CFG_MAX_DELAY:     r_max_dly   <= i_cfg_ch.data[lbl_pkg::DELAY_W-1:0];
                    lbl_pkg::CFG_RETENTION:     r_retention <= i_cfg_ch.data;
                    default: begin
                    end
                endcase
            end

            // Drop the result after its transfer unless the final step reloads it
            if (o_res_ch.valid && o_res_ch.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // Compare stage of the scan
            r_cmp_vld <= (r_state == ST_SCAN);
            if (cmp_hit) begin
                if (r_cmd == lbl_pkg::CMD_RESET) begin
                    r_valid[r_cmp_idx] <= 1'b0;
                end else begin
                    r_match <= 1'b1;
                end
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx]) begin
                r_free_found <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_ch.valid) begin
                        r_cmd         <= i_cmd_ch.cmd;
                        r_user        <= i_cmd_ch.user_id;
                        r_addr        <= i_cmd_ch.remote_addr;
                        r_now         <= i_cmd_ch.now_seconds;
                        r_scan_idx    <= '0;
                        r_match       <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_res_allowed <= 1'b0;
                        r_res_retry   <= '0;
                        r_res_full    <= 1'b0;
                        r_state       <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_scan_idx == IW'(lbl_pkg::ENTRIES - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    case (r_cmd)
                        lbl_pkg::CMD_CHECK: begin
                            r_res_allowed <= 1'b1;
                            r_state       <= r_match ? ST_CK_ELAP : ST_DONE;
                        end
                        lbl_pkg::CMD_FAILURE: begin
                            if (r_match || r_free_found) begin
                                r_n     <= n_fail_cnt;
                                r_k     <= 8'd1;
                                r_dly   <= r_init_dly;
                                r_state <= ST_FL_DLY;
                            end else begin
                                r_res_full <= 1'b1;
                                r_state    <= ST_DONE;
                            end
                        end
                        lbl_pkg::CMD_SUCCESS: begin
                            if (r_match) begin
                                r_valid[r_slot] <= 1'b0;
                            end
                            r_state <= ST_DONE;
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_CK_ELAP: begin
                    // Time going backwards counts as no time elapsed
                    r_elapsed <= alu_rsp.carry ? '0 : alu_rsp.res[lbl_pkg::TIME_W-1:0];
                    r_state   <= ST_CK_RET;
                end
                ST_CK_RET: begin
                    if (alu_rsp.carry) begin
                        r_valid[r_slot] <= 1'b0;
                        r_state         <= ST_DONE;
                    end else begin
                        r_state <= ST_CK_BLK;
                    end
                end
                ST_CK_BLK: begin
                    if (!alu_rsp.carry && (alu_rsp.res != '0)) begin
                        r_res_allowed <= 1'b0;
                        r_res_retry   <= (|alu_rsp.res[lbl_pkg::BLOCK_W-1:lbl_pkg::DELAY_W])
                                         ? lbl_pkg::RETRY_MAX
                                         : alu_rsp.res[lbl_pkg::DELAY_W-1:0];
                    end
                    r_state <= ST_DONE;
                end
                ST_FL_DLY: begin
                    if (dly_go) begin
                        r_dly <= n_dly;
                        r_k   <= r_k + 1'b1;
                    end else begin
                        r_state <= ST_FL_ADD;
                    end
                end
                ST_FL_ADD: begin
                    r_valid[wr_idx] <= 1'b1;
                    r_state         <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || o_res_ch.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_allowed <= r_res_allowed;
                        r_out_retry   <= r_res_retry;
                        r_out_full    <= r_res_full;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A transfer in starts the scan
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ch.valid && i_cmd_ch.ready) |=> (r_state == ST_SCAN))
        else $error("accepted command did not start a scan");

    // A full table result never grants or asks for a wait
    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && o_res_ch.table_full) |->
        (!o_res_ch.access_allowed && (o_res_ch.retry_after == '0)))
        else $error("table_full combined with a check result");

    // A wait is reported only on a denial
    a_retry_denied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && (o_res_ch.retry_after != '0)) |-> !o_res_ch.access_allowed)
        else $error("retry_after set while access granted");

    // A new result only loads from the final step
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the final step");

endmodule
